/* rtl/pdbc_pkg.sv */
package pdbc_pkg;

    localparam int SAMPLE_W = 32;
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 2;

    // sample_width codes; the unused code falls back to 8 bits
    localparam logic [CFG_W-1:0] WIDTH_8  = 2'd0;
    localparam logic [CFG_W-1:0] WIDTH_16 = 2'd1;
    localparam logic [CFG_W-1:0] WIDTH_32 = 2'd2;

    localparam logic [CFG_W-1:0] CH_MONO   = 2'd1;
    localparam logic [CFG_W-1:0] CH_STEREO = 2'd2;

    localparam logic [CFG_W-1:0] MODE_STEREO = 2'd0;
    localparam logic [CFG_W-1:0] MODE_MIX    = 2'd1;
    localparam logic [CFG_W-1:0] MODE_LEFT   = 2'd2;
    localparam logic [CFG_W-1:0] MODE_RIGHT  = 2'd3;

    localparam logic [1:0] REG_SAMPLE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] REG_OUTPUT_MODE   = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] sample_width;
        logic [CFG_W-1:0] channel_count;
        logic [CFG_W-1:0] output_mode;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic              two;
    } frame_t;

    // Sign-extend the low bits of a field at the configured width.
    function automatic logic [SAMPLE_W-1:0] take_sample(
        input logic [SAMPLE_W-1:0] raw,
        input logic [CFG_W-1:0]    w
    );
        logic [SAMPLE_W-1:0] s;
        case (w)
            WIDTH_32: s = raw;
            WIDTH_16: s = {{(SAMPLE_W-16){raw[15]}}, raw[15:0]};
            default:  s = {{(SAMPLE_W-8){raw[7]}}, raw[7:0]};
        endcase
        return s;
    endfunction

    // Divide by two, truncating toward zero.
    function automatic logic [SAMPLE_W-1:0] halve(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] fl;
        fl = {s[SAMPLE_W-1], s[SAMPLE_W-1:1]};
        return fl + {{(SAMPLE_W-1){1'b0}}, s[SAMPLE_W-1] & s[0]};
    endfunction

    // Divide toward zero by the width's scale, keep the low byte.
    // Floor division is a bit-select; add one when negative with a remainder.
    function automatic logic [BYTE_W-1:0] to_byte(
        input logic [SAMPLE_W-1:0] s,
        input logic [CFG_W-1:0]    w
    );
        logic [BYTE_W-1:0] b;
        case (w)
            WIDTH_32: b = s[31:24] + {{(BYTE_W-1){1'b0}}, s[31] & (|s[23:0])};
            WIDTH_16: b = s[15:8] + {{(BYTE_W-1){1'b0}}, s[31] & (|s[7:0])};
            default:  b = s[7:0];
        endcase
        return b;
    endfunction

endpackage

/* rtl/pdbc_cfg.sv */
module pdbc_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [pdbc_pkg::CFG_W-1:0] cfg_data,
    output pdbc_pkg::cfg_t             cfg
);

    pdbc_pkg::cfg_t cfg_reg;
    pdbc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                pdbc_pkg::REG_SAMPLE_WIDTH:  cfg_next.sample_width  = cfg_data;
                pdbc_pkg::REG_CHANNEL_COUNT: cfg_next.channel_count = cfg_data;
                pdbc_pkg::REG_OUTPUT_MODE:   cfg_next.output_mode   = cfg_data;
                default:                     cfg_next = cfg_reg; // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_width  <= pdbc_pkg::WIDTH_16;
            cfg_reg.channel_count <= pdbc_pkg::CH_STEREO;
            cfg_reg.output_mode   <= pdbc_pkg::MODE_STEREO;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/pdbc_conv.sv */
module pdbc_conv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pdbc_pkg::cfg_t                cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [2*pdbc_pkg::SAMPLE_W-1:0] s_tdata,
    output logic                          frm_valid,
    input  logic                          frm_take,
    output pdbc_pkg::frame_t              frm
);

    logic                            valid_reg;
    logic                            valid_next;
    logic [pdbc_pkg::SAMPLE_W-1:0]   left_reg;
    logic [pdbc_pkg::SAMPLE_W-1:0]   right_reg;
    logic [pdbc_pkg::SAMPLE_W-1:0]   left_s;
    logic [pdbc_pkg::SAMPLE_W-1:0]   right_s;
    logic [pdbc_pkg::SAMPLE_W-1:0]   mix_s;
    logic [pdbc_pkg::BYTE_W-1:0]     left_b;
    logic [pdbc_pkg::BYTE_W-1:0]     right_b;
    logic [pdbc_pkg::BYTE_W-1:0]     mix_b;
    logic                            load;

    // Input register frees up when its frame moves on to the output stage.
    assign s_tready  = !valid_reg || frm_take;
    assign load      = s_tvalid && s_tready;
    assign frm_valid = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (frm_take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_reg  <= s_tdata[pdbc_pkg::SAMPLE_W-1:0];
            right_reg <= s_tdata[2*pdbc_pkg::SAMPLE_W-1:pdbc_pkg::SAMPLE_W];
        end
    end

    always_comb
    begin
        left_s  = pdbc_pkg::take_sample(left_reg, cfg.sample_width);
        right_s = pdbc_pkg::take_sample(right_reg, cfg.sample_width);
        mix_s   = pdbc_pkg::halve(left_s) + pdbc_pkg::halve(right_s);
        left_b  = pdbc_pkg::to_byte(left_s, cfg.sample_width);
        right_b = pdbc_pkg::to_byte(right_s, cfg.sample_width);
        mix_b   = pdbc_pkg::to_byte(mix_s, cfg.sample_width);

        frm.byte0 = left_b;
        frm.byte1 = left_b;
        frm.two   = (cfg.output_mode == pdbc_pkg::MODE_STEREO);
        if (cfg.channel_count != pdbc_pkg::CH_MONO)
        begin
            case (cfg.output_mode)
                pdbc_pkg::MODE_STEREO: frm.byte1 = right_b;
                pdbc_pkg::MODE_MIX:    frm.byte0 = mix_b;
                pdbc_pkg::MODE_LEFT:   frm.byte0 = left_b;
                default:               frm.byte0 = right_b;
            endcase
        end
    end

endmodule

/* rtl/pdbc_out.sv */
module pdbc_out (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         frm_valid,
    output logic                         frm_take,
    input  pdbc_pkg::frame_t             frm,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pdbc_pkg::BYTE_W-1:0]  m_tdata,
    output logic                         m_tlast
);

    logic             valid_reg;
    logic             valid_next;
    logic             sel_reg;
    logic             sel_next;
    pdbc_pkg::frame_t frm_reg;
    logic             free;
    logic             xfer;

    assign m_tvalid = valid_reg;
    assign m_tdata  = sel_reg ? frm_reg.byte1 : frm_reg.byte0;
    assign m_tlast  = !frm_reg.two || sel_reg;
    assign xfer     = valid_reg && m_tready;
    // Buffer is free when empty or its final byte transfers this cycle.
    assign free     = !valid_reg || (m_tready && m_tlast);
    assign frm_take = frm_valid && free;

    always_comb
    begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        if (frm_take)
        begin
            valid_next = 1'b1;
            sel_next   = 1'b0;
        end
        else if (xfer)
        begin
            if (m_tlast)
                valid_next = 1'b0;
            else
                sel_next = 1'b1; // advance to second byte
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frm_take)
            frm_reg <= frm;
    end

endmodule

/* rtl/pcm_to_dac_byte_converter.sv */
// PCM to DAC byte converter.
// Input stream (s_*): one audio frame per transfer, s_tdata holds sample_left in
// bits 31:0 and sample_right in bits 63:32, each sign-extended from the width set
// in sample_width (8, 16 or 32 bits). sample_right is ignored for mono input.
// Output stream (m_*): one 8-bit DAC byte per transfer, m_tlast high on the final
// byte of a frame. A frame gives two bytes when output_mode is stereo, else one.
// Configuration (cfg_*): register index 0 sample_width, 1 channel_count,
// 2 output_mode; write only while no frame is in flight.
// The input register loads a frame at its input transfer and passes it to the
// output buffer once it is free; the output buffer then offers the first byte.
// Throughput: one frame per cycle for single-byte frames while m_tready stays high;
// a two-byte frame sends its bytes in turn over the single output byte lane, and
// the next frame waits until its last byte transfers.
// Reset clears both pipeline stages and loads 16-bit samples, stereo input and
// stereo output. When the receiver stalls, the output buffer holds its byte, the
// input register holds one more frame, and s_tready then drops until the output
// buffer drains.
module pcm_to_dac_byte_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // sample_left [31:0], sample_right [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // dac_byte [7:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);

    pdbc_pkg::cfg_t   cfg;
    pdbc_pkg::frame_t frm;
    logic             frm_valid;
    logic             frm_take;

    pdbc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdbc_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .frm_valid (frm_valid),
        .frm_take  (frm_take),
        .frm       (frm)
    );

    pdbc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .frm_valid (frm_valid),
        .frm_take  (frm_take),
        .frm       (frm),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // A first byte that transfers is always followed by the frame's last byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
        else $error("second byte of frame missing");

    // Input side stalls only while a frame waits behind a busy output buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (frm_valid && m_tvalid))
        else $error("input stalled with free pipeline");

    // A frame in the input register moves on once the output buffer drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        (frm_valid && !m_tvalid) |-> frm_take)
        else $error("frame not forwarded to empty output buffer");

endmodule

/* verif/dac_byte_monitor.sv */
`timescale 1ns / 1ps
module dac_byte_monitor
    import pdbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,     // sample_left [31:0], sample_right [63:32]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,     // dac_byte [7:0]
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data,
    output int          mismatches,
    output int          bytes_owed
);

    typedef struct packed {
        logic [BYTE_W-1:0] dac_byte;
        logic              last;
    } dac_out_t;

    localparam int SCALE_32   = 1 << 24;
    localparam int SCALE_16   = 1 << 8;
    localparam int REPORT_MAX = 10;

    logic [CFG_W-1:0] width_cfg;
    logic [CFG_W-1:0] chan_cfg;
    logic [CFG_W-1:0] mode_cfg;
    dac_out_t         owed_q[$];
    dac_out_t         want;

    // Sign-extend a field from the configured sample width.
    function automatic int widen(logic [SAMPLE_W-1:0] raw, logic [CFG_W-1:0] w);
        logic signed [15:0] half_word;
        logic signed [7:0]  low_byte;
        half_word = raw[15:0];
        low_byte  = raw[7:0];
        case (w)
            WIDTH_32: return $signed(raw);
            WIDTH_16: return half_word;
            default:  return low_byte;
        endcase
    endfunction

    // Integer division in SystemVerilog truncates toward zero.
    function automatic logic [BYTE_W-1:0] dac_code(int s, logic [CFG_W-1:0] w);
        int q;
        case (w)
            WIDTH_32: q = s / SCALE_32;
            WIDTH_16: q = s / SCALE_16;
            default:  q = s;
        endcase
        return q[BYTE_W-1:0];
    endfunction

    task automatic predict_frame(logic [63:0] frame);
        int                left;
        int                right;
        logic [BYTE_W-1:0] b;
        left  = widen(frame[31:0], width_cfg);
        right = widen(frame[63:32], width_cfg);
        if (chan_cfg == CH_MONO)
        begin
            b = dac_code(left, width_cfg);
            if (mode_cfg == MODE_STEREO)
                owed_q.push_back({b, 1'b0});
            owed_q.push_back({b, 1'b1});
        end
        else if (mode_cfg == MODE_STEREO)
        begin
            owed_q.push_back({dac_code(left, width_cfg), 1'b0});
            owed_q.push_back({dac_code(right, width_cfg), 1'b1});
        end
        else
        begin
            case (mode_cfg)
                MODE_MIX:  b = dac_code(left / 2 + right / 2, width_cfg);
                MODE_LEFT: b = dac_code(left, width_cfg);
                default:   b = dac_code(right, width_cfg);
            endcase
            owed_q.push_back({b, 1'b1});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg  = WIDTH_16;
            chan_cfg   = CH_STEREO;
            mode_cfg   = MODE_STEREO;
            owed_q.delete();
            mismatches = 0;
            bytes_owed = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (owed_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected byte %02h last %0b", $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (m_tdata !== want.dac_byte || m_tlast !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: dac_byte exp %02h got %02h, last exp %0b got %0b",
                                     $time, want.dac_byte, m_tdata, want.last, m_tlast);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SAMPLE_WIDTH:  width_cfg = cfg_data;
                    REG_CHANNEL_COUNT: chan_cfg  = cfg_data;
                    REG_OUTPUT_MODE:   mode_cfg  = cfg_data;
                    default:           ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_frame(s_tdata);
            bytes_owed = owed_q.size();
        end
    end

endmodule

/* verif/pcm_to_dac_byte_converter_tb.sv */
`timescale 1ns / 1ps
module pcm_to_dac_byte_converter_tb;
    import pdbc_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int PHASES           = 32;
    localparam int FRAMES_PER_PHASE = 56;
    localparam int SETTLE_CYCLES    = 4;

    localparam logic [CFG_W-1:0] WIDTH_RSVD = 2'd3;
    localparam logic [CFG_W-1:0] CH_NONE    = 2'd0;
    localparam logic [CFG_W-1:0] CH_TRIPLE  = 2'd3;
    localparam logic [1:0]       REG_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [1:0]  cfg_data;

    int               mismatches;
    int               bytes_owed;
    int               cycles = 0;
    bit               calm = 1'b0;
    logic [CFG_W-1:0] cur_width;

    pcm_to_dac_byte_converter DUT (.*);

    dac_byte_monitor monitor (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL pcm_to_dac_byte_converter");
            $finish;
        end
    end

    // Receiver: random stall before each byte, none while calm.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Hold off the sender until every predicted byte has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] ch,
                             logic [CFG_W-1:0] mode, bit poke_unused = 1'b0);
        drain();
        write_reg(REG_SAMPLE_WIDTH, w);
        write_reg(REG_CHANNEL_COUNT, ch);
        write_reg(REG_OUTPUT_MODE, mode);
        if (poke_unused)
            write_reg(REG_UNUSED, CFG_W'($urandom));
        cfg_valid <= 1'b0;
        cur_width = w;
    endtask

    task automatic frame(logic [31:0] left, logic [31:0] right);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        do @(posedge clk); while (!s_tready);
    endtask

    // Sample at the active width, with junk above it; favors edges and scale steps.
    function automatic logic [31:0] pick_sample(logic [CFG_W-1:0] w);
        int          nbits;
        int          shift;
        logic [31:0] v;
        logic [31:0] mask;
        nbits = (w == WIDTH_32) ? 32 : (w == WIDTH_16) ? 16 : 8;
        shift = (w == WIDTH_32) ? 24 : (w == WIDTH_16) ? 8 : 0;
        mask  = (nbits == 32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 32'd1);
        case ($urandom_range(0, 9))
            5:       v = 32'd1 << (nbits - 1);
            6:       v = (32'd1 << (nbits - 1)) - 32'd1;
            7:       v = $urandom_range(0, 3) - 2;
            8:       v = ($urandom << shift) + $urandom_range(0, 2) - 1;
            9:       v = {32{1'($urandom_range(0, 1))}};
            default: v = $urandom;
        endcase
        return (v & mask) | ($urandom & ~mask);
    endfunction

    initial
    begin
        logic [CFG_W-1:0] width_codes [4];
        logic [CFG_W-1:0] mode_codes [4];
        logic [CFG_W-1:0] chan;
        width_codes = '{WIDTH_8, WIDTH_16, WIDTH_32, WIDTH_RSVD};
        mode_codes  = '{MODE_STEREO, MODE_MIX, MODE_LEFT, MODE_RIGHT};
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SAMPLE_WIDTH;
        cfg_data  <= '0;
        cur_width = WIDTH_16;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 16-bit stereo in, stereo out; range ends and rounding toward zero
        frame(32'h0000_7FFF, 32'h0000_8000);
        frame(32'hFFFF_FF00, 32'h0000_FF01);
        frame(32'hA5A5_00FF, 32'h5A5A_0100);
        frame(32'hFFFF_FFFF, 32'h0000_0000);

        configure(WIDTH_32, CH_STEREO, MODE_MIX);
        frame(32'h8000_0000, 32'h8000_0000);
        frame(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        frame(32'h8000_0001, 32'h7FFF_FFFF);
        frame(32'hFFFF_FFFF, 32'h0000_0001);

        configure(WIDTH_32, CH_STEREO, MODE_STEREO);
        frame(32'hFF00_0000, 32'hFEFF_FFFF);
        frame(32'hFF00_0001, 32'h0100_0000);

        // Write to the unused index must leave the settings alone
        configure(WIDTH_8, CH_STEREO, MODE_LEFT, 1'b1);
        frame(32'h0000_007F, 32'h0000_0080);
        frame(32'hFFFF_FF80, 32'h0000_007F);

        configure(WIDTH_8, CH_STEREO, MODE_RIGHT);
        frame(32'h1234_5601, 32'hABCD_EF80);

        // Unused width code falls back to 8 bits; mono to stereo doubles the byte
        configure(WIDTH_RSVD, CH_MONO, MODE_STEREO);
        frame(32'h0000_00FF, $urandom);
        frame(32'h0000_0080, $urandom);

        // Mono input skips the halving of the mix
        configure(WIDTH_16, CH_MONO, MODE_MIX);
        frame(32'h0000_8000, $urandom);
        frame(32'h0000_7FFF, $urandom);

        configure(WIDTH_32, CH_MONO, MODE_RIGHT);
        frame(32'h7FFF_FFFF, 32'h8000_0000);

        // Odd channel counts behave as stereo
        configure(WIDTH_16, CH_NONE, MODE_STEREO);
        frame(32'h0000_1234, 32'h0000_FEDC);

        configure(WIDTH_16, CH_TRIPLE, MODE_MIX);
        frame(32'h0000_8000, 32'h0000_8000);
        frame(32'h0000_7FFF, 32'h0000_8001);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p >= PHASES / 2)
                chan = CH_MONO;
            else if (p % 5 == 0)
                chan = $urandom_range(0, 1) ? CH_NONE : CH_TRIPLE;
            else
                chan = CH_STEREO;
            configure(width_codes[p % 4], chan, mode_codes[(p / 4) % 4]);
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < FRAMES_PER_PHASE; i++)
            begin
                if (i == FRAMES_PER_PHASE / 2 && (p == 0 || $urandom_range(0, 7) == 0))
                    drain();
                frame(pick_sample(cur_width), pick_sample(cur_width));
            end
        end

        drain();
        if (mismatches == 0)
            $display("PASS pcm_to_dac_byte_converter");
        else
            $display("FAIL pcm_to_dac_byte_converter");
        $finish;
    end

endmodule
